### src/xsr_pkg.sv
// Package for the bounded xorshift64* random core: constants, types and the seed mix.
package xsr_pkg;

  localparam int unsigned WORD_W = 64;
  localparam int unsigned HALF_W = WORD_W / 2;

  localparam logic [WORD_W-1:0] GOLDEN_GAMMA = 64'h9E37_79B9_7F4A_7C15;
  localparam logic [WORD_W-1:0] MIX_MUL_1    = 64'hBF58_476D_1CE4_E5B9;
  localparam logic [WORD_W-1:0] MIX_MUL_2    = 64'h94D0_49BB_1331_11EB;
  localparam logic [WORD_W-1:0] STAR_MUL     = 64'h2545_F491_4F6C_DD1D;
  localparam logic [WORD_W-1:0] RESET_SEED   = 64'd20260701;

  localparam int unsigned XS_SHIFT_A  = 12;
  localparam int unsigned XS_SHIFT_B  = 25;
  localparam int unsigned XS_SHIFT_C  = 27;
  localparam int unsigned MIX_SHIFT_A = 30;
  localparam int unsigned MIX_SHIFT_B = 27;
  localparam int unsigned MIX_SHIFT_C = 31;

  // The 64-bit product is built from three 32x32 partial products.
  localparam int unsigned MUL_STEPS  = 3;
  localparam int unsigned MUL_STEP_W = $clog2(MUL_STEPS);
  localparam logic [MUL_STEP_W-1:0] MUL_STEP_LO    = MUL_STEP_W'(0);
  localparam logic [MUL_STEP_W-1:0] MUL_STEP_CROSS = MUL_STEP_W'(1);
  localparam logic [MUL_STEP_W-1:0] MUL_STEP_LAST  = MUL_STEP_W'(MUL_STEPS - 1);

  // One quotient bit per cycle.
  localparam int unsigned DIV_CNT_W = $clog2(WORD_W);

  // Command queue between the front and the back.
  localparam int unsigned QDEPTH  = 2;
  localparam int unsigned QPTR_W  = $clog2(QDEPTH);
  localparam int unsigned QCOUNT_W = $clog2(QDEPTH + 1);

  localparam logic KIND_DRAW   = 1'b0;
  localparam logic KIND_RESEED = 1'b1;

  typedef enum logic [1:0] {
    OP_DRAW,
    OP_ZERO,
    OP_RESEED
  } xsr_op_t;

  typedef struct packed {
    xsr_op_t           op;
    logic [WORD_W-1:0] bound;
  } xsr_cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_DONE
  } xsr_state_t;

  typedef enum logic [1:0] {
    PH_MIX1,
    PH_MIX2,
    PH_DRAW
  } xsr_phase_t;

  // Full splitmix64 mix; only evaluated on constants at elaboration.
  function automatic logic [WORD_W-1:0] mix_seed(input logic [WORD_W-1:0] s);
    logic [WORD_W-1:0] z;
    z = s + GOLDEN_GAMMA;
    z = (z ^ (z >> MIX_SHIFT_A)) * MIX_MUL_1;
    z = (z ^ (z >> MIX_SHIFT_B)) * MIX_MUL_2;
    return z ^ (z >> MIX_SHIFT_C);
  endfunction

  localparam logic [WORD_W-1:0] RESET_STATE = mix_seed(RESET_SEED);

endpackage

### src/xsr_front.sv
// Front end: takes input items, classifies them and pushes commands into the queue.
module xsr_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              kind,
  input  logic [63:0]       bound,
  output logic              push,
  output xsr_pkg::xsr_cmd_t push_cmd,
  input  logic              full
);
  import xsr_pkg::*;

  logic     held;
  xsr_cmd_t cmd;
  xsr_cmd_t cmd_next;

  assign push     = held && !full;
  assign push_cmd = cmd;
  assign in_ready = !held || !full;

  always_comb begin
    cmd_next.bound = bound;
    if (kind == KIND_RESEED) begin
      cmd_next.op = OP_RESEED;
    end else if (bound == '0) begin
      cmd_next.op = OP_ZERO;
    end else begin
      cmd_next.op = OP_DRAW;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (in_valid && in_ready) begin
      held <= 1'b1;
    end else if (push) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd <= cmd_next;
    end
  end

endmodule

### src/xsr_queue.sv
// Short command queue that decouples the front end from the back end.
module xsr_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  xsr_pkg::xsr_cmd_t push_cmd,
  output logic              full,
  input  logic              pop,
  output xsr_pkg::xsr_cmd_t head,
  output logic              empty
);
  import xsr_pkg::*;

  xsr_cmd_t            entries [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCOUNT_W-1:0] count;

  assign full  = (count == QCOUNT_W'(QDEPTH));
  assign empty = (count == '0);
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= QPTR_W'(wr_ptr + 1'b1);
      end
      if (pop) begin
        rd_ptr <= QPTR_W'(rd_ptr + 1'b1);
      end
      if (push && !pop) begin
        count <= QCOUNT_W'(count + 1'b1);
      end else if (pop && !push) begin
        count <= QCOUNT_W'(count - 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule

### src/xsr_back.sv
// Back end: generator state, seed mix, shared 32x32 multiplier, serial divider, result register.
module xsr_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  logic [63:0]       cfg_wr_data,
  input  xsr_pkg::xsr_cmd_t head,
  input  logic              empty,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [63:0]       value
);
  import xsr_pkg::*;

  xsr_state_t            state, state_next;
  xsr_phase_t            phase, phase_next;
  logic [MUL_STEP_W-1:0] step, step_next;
  logic [DIV_CNT_W-1:0]  cnt, cnt_next;
  logic                  out_valid_next;

  logic [WORD_W-1:0] seed;
  logic [WORD_W-1:0] gen, gen_next;
  logic [WORD_W-1:0] mul_a, mul_a_next;
  logic [WORD_W-1:0] acc, acc_next;
  logic [WORD_W-1:0] dvd, dvd_next;
  logic [WORD_W-1:0] rem, rem_next;
  logic [WORD_W-1:0] dsr, dsr_next;
  logic [WORD_W-1:0] res, res_next;
  logic [WORD_W-1:0] value_next;

  logic [WORD_W-1:0] konst;
  logic [HALF_W-1:0] mop_a;
  logic [HALF_W-1:0] mop_b;
  logic [WORD_W-1:0] prod;
  logic [WORD_W-1:0] acc_sum;
  logic [WORD_W-1:0] seed_z;
  logic [WORD_W-1:0] xs1, xs2, xs3;
  logic [WORD_W:0]   rem_sh;
  logic [WORD_W:0]   rem_diff;
  logic [WORD_W-1:0] rem_new;

  // Multiplier operand and constant selection.
  always_comb begin
    unique case (phase)
      PH_MIX1: konst = MIX_MUL_1;
      PH_MIX2: konst = MIX_MUL_2;
      PH_DRAW: konst = STAR_MUL;
      default: konst = STAR_MUL;
    endcase
    mop_a   = (step == MUL_STEP_LAST) ? mul_a[WORD_W-1:HALF_W] : mul_a[HALF_W-1:0];
    mop_b   = (step == MUL_STEP_CROSS) ? konst[WORD_W-1:HALF_W] : konst[HALF_W-1:0];
    prod    = mop_a * mop_b;
    acc_sum = acc + {prod[HALF_W-1:0], {HALF_W{1'b0}}};
  end

  // Datapath helpers: seed offset, xorshift step, restoring divide step.
  always_comb begin
    seed_z   = seed + GOLDEN_GAMMA;
    xs1      = gen ^ (gen >> XS_SHIFT_A);
    xs2      = xs1 ^ (xs1 << XS_SHIFT_B);
    xs3      = xs2 ^ (xs2 >> XS_SHIFT_C);
    rem_sh   = {rem, dvd[WORD_W-1]};
    rem_diff = rem_sh - {1'b0, dsr};
    rem_new  = rem_diff[WORD_W] ? rem_sh[WORD_W-1:0] : rem_diff[WORD_W-1:0];
  end

  always_comb begin
    state_next     = state;
    phase_next     = phase;
    step_next      = step;
    cnt_next       = cnt;
    gen_next       = gen;
    mul_a_next     = mul_a;
    acc_next       = acc;
    dvd_next       = dvd;
    rem_next       = rem;
    dsr_next       = dsr;
    res_next       = res;
    value_next     = value;
    out_valid_next = out_valid && !out_ready;
    pop            = 1'b0;

    unique case (state)
      ST_IDLE: begin
        if (!empty) begin
          pop       = 1'b1;
          step_next = MUL_STEP_LO;
          unique case (head.op)
            OP_RESEED: begin
              mul_a_next = seed_z ^ (seed_z >> MIX_SHIFT_A);
              phase_next = PH_MIX1;
              state_next = ST_MUL;
            end
            OP_DRAW: begin
              gen_next   = xs3;
              mul_a_next = xs3;
              dsr_next   = head.bound;
              phase_next = PH_DRAW;
              state_next = ST_MUL;
            end
            default: begin
              res_next   = '0;
              state_next = ST_DONE;
            end
          endcase
        end
      end

      ST_MUL: begin
        if (step == MUL_STEP_LO) begin
          acc_next = prod;
        end else begin
          acc_next = acc_sum;
        end
        step_next = MUL_STEP_W'(step + 1'b1);
        if (step == MUL_STEP_LAST) begin
          step_next = MUL_STEP_LO;
          unique case (phase)
            PH_MIX1: begin
              mul_a_next = acc_sum ^ (acc_sum >> MIX_SHIFT_B);
              phase_next = PH_MIX2;
            end
            PH_MIX2: begin
              gen_next   = acc_sum ^ (acc_sum >> MIX_SHIFT_C);
              res_next   = '0;
              state_next = ST_DONE;
            end
            default: begin
              dvd_next   = acc_sum;
              rem_next   = '0;
              cnt_next   = '0;
              state_next = ST_DIV;
            end
          endcase
        end
      end

      ST_DIV: begin
        rem_next = rem_new;
        dvd_next = dvd << 1;
        cnt_next = DIV_CNT_W'(cnt + 1'b1);
        if (cnt == '1) begin
          res_next   = rem_new;
          state_next = ST_DONE;
        end
      end

      ST_DONE: begin
        if (!out_valid || out_ready) begin
          value_next     = res;
          out_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      seed      <= RESET_SEED;
      gen       <= RESET_STATE;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
      gen       <= gen_next;
      if (cfg_wr_en) begin
        seed <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    phase <= phase_next;
    step  <= step_next;
    cnt   <= cnt_next;
    mul_a <= mul_a_next;
    acc   <= acc_next;
    dvd   <= dvd_next;
    rem   <= rem_next;
    dsr   <= dsr_next;
    res   <= res_next;
    value <= value_next;
  end

endmodule

### src/xorshift64star_bounded_random_core.sv
// Top level of the bounded xorshift64* random core with splitmix64 reseeding.
//
//   channel   handshake               payload
//   -------   ---------------------   ---------------------------
//   input     in_valid / in_ready     kind (1 bit), bound (64 bits)
//   output    out_valid / out_ready   value (64 bits)
//   config    cfg_wr_en               cfg_wr_data (seed_value, 64 bits)
//
// A draw with a nonzero bound runs through the back end in these steps: the
// xorshift step, the three 32x32 partial products of the scrambling multiply,
// and the one-bit-per-cycle restoring divider that forms the remainder. A
// reseed runs two three-step multiplies, and a draw with a zero bound gives
// zero without the multiplier or divider. Reset (rst, synchronous) loads the generator
// with the splitmix64 mix of the default seed at once; no clearing pass is run.
// The front end and a two-entry queue keep taking items while the back end works,
// and the result register lets the back end finish the next item while a result
// waits on out_ready.
module xorshift64star_bounded_random_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        kind,
  input  logic [63:0] bound,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] value,
  input  logic        cfg_wr_en,
  input  logic [63:0] cfg_wr_data
);
  import xsr_pkg::*;

  // Commands that the front end has classified travel through the queue.
  logic     push;
  xsr_cmd_t push_cmd;
  logic     full;
  logic     pop;
  xsr_cmd_t head;
  logic     empty;

  // The front end sorts items into draws, zero-bound draws and reseeds.
  xsr_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .kind     (kind),
    .bound    (bound),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (full)
  );

  xsr_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (full),
    .pop      (pop),
    .head     (head),
    .empty    (empty)
  );

  // The back end owns the generator state and the seed register, and it
  // executes one command at a time in queue order.
  xsr_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .head        (head),
    .empty       (empty),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .value       (value)
  );

endmodule
